// ----- hdl/snf_pkg.sv -----
// Shared types, constants and helper functions for the SEI NAL framer.
// No dependencies; the loader, emitter, top level and verification files refer to this package.
package snf_pkg;

	localparam int PAYLOAD_DEPTH = 4096;
	localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
	localparam int CNT_W = ADDR_W + 1;
	localparam int QUOT_W = $clog2(PAYLOAD_DEPTH / 255 + 2);
	localparam int NAL_W = ADDR_W + 2;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CODEC_SELECT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMING_MODE = 1'b1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic [7:0] TRAIL_BYTE = 8'h80;
	localparam logic [7:0] H265_HDR0 = 8'(39 << 1);
	localparam logic [7:0] H265_HDR1 = 8'd1;
	localparam logic [7:0] H264_HDR = 8'd6;
	localparam logic [7:0] SEI_TYPE = 8'd5;
	localparam logic [7:0] LEN_RUN = 8'd255;
	localparam logic [7:0] EPB = 8'd3;
	localparam logic [7:0] REM_WRAP = 8'd254;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_HEADER,
		PH_TYPE,
		PH_LEN,
		PH_REM,
		PH_PAY,
		PH_TRAIL
	} snf_phase_t;

	typedef struct packed {
		logic ready;
		logic overflow;
		logic [CNT_W-1:0] count;
		logic [QUOT_W-1:0] quot;
		logic [7:0] rem;
		logic [NAL_W-1:0] nal_size;
	} snf_msg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic last_out;
		logic done;
	} snf_emit_t;

	typedef struct packed {
		logic inc;
		logic [1:0] zr;
	} snf_esc_t;

	// One step of the zero-run tracker: flags an inserted 3 and gives the new run.
	function automatic snf_esc_t esc_step(input logic [1:0] zr, input logic [7:0] d);
		snf_esc_t r;
		r.inc = (zr == 2'd2) && (d <= EPB);
		if (d != 8'd0) begin
			r.zr = 2'd0;
		end else if (r.inc) begin
			r.zr = 2'd1;
		end else if (zr == 2'd2) begin
			r.zr = 2'd2;
		end else begin
			r.zr = zr + 2'd1;
		end
		return r;
	endfunction

endpackage

// ----- hdl/snf_if.sv -----
// Valid/ready channel interfaces for input and result transactions of the framer.
// Depends on nothing; payload fields are fixed-width bytes and flags.
interface snf_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [7:0] data_byte;
	logic last_byte;

	modport source (output valid, output operation, output data_byte, output last_byte,
		input ready);
	modport sink (input valid, input operation, input data_byte, input last_byte,
		output ready);
endinterface

interface snf_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_out;
	logic error_flag;

	modport source (output valid, output out_byte, output last_out, output error_flag,
		input ready);
	modport sink (input valid, input out_byte, input last_out, input error_flag,
		output ready);
endinterface

// ----- hdl/snf_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package dependencies.
module snf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/snf_loader.sv -----
// Message accounting for the framer: byte count, length-code split and escape count.
// Depends on snf_pkg; drives the payload RAM write port and the message summary.
module snf_loader (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_en,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic                  codec_select,
	input  logic                  done,
	output logic                  wr_en,
	output logic [snf_pkg::ADDR_W-1:0] wr_addr,
	output snf_pkg::snf_msg_t     msg
);

	logic [snf_pkg::CNT_W-1:0]  count_q, base_count, count_n;
	logic [snf_pkg::QUOT_W-1:0] quot_q, base_quot, quot_n;
	logic [7:0]                 rem_q, base_rem, rem_n;
	logic [1:0]                 zr_a_q, zr_b_q, base_zr_a, base_zr_b;
	logic [snf_pkg::CNT_W-1:0]  esc_a_q, esc_b_q, base_esc_a, base_esc_b, esc_a_n, esc_b_n;
	logic [snf_pkg::CNT_W-1:0]  esc_sel;
	logic                       ready_q, ovf_q, base_ovf;
	logic [snf_pkg::NAL_W-1:0]  nal_size_q, nal_size_n;
	logic                       store;
	snf_pkg::snf_esc_t          step_a, step_b;

	// A load after a finished message starts over from a cleared message.
	always_comb begin
		if (ready_q) begin
			base_count = '0;
			base_quot = '0;
			base_rem = '0;
			base_zr_a = 2'd0;
			base_zr_b = 2'd1;
			base_esc_a = '0;
			base_esc_b = '0;
			base_ovf = 1'b0;
		end else begin
			base_count = count_q;
			base_quot = quot_q;
			base_rem = rem_q;
			base_zr_a = zr_a_q;
			base_zr_b = zr_b_q;
			base_esc_a = esc_a_q;
			base_esc_b = esc_b_q;
			base_ovf = ovf_q;
		end
		store = base_count < snf_pkg::CNT_W'(snf_pkg::PAYLOAD_DEPTH);
		step_a = snf_pkg::esc_step(base_zr_a, data_byte);
		step_b = snf_pkg::esc_step(base_zr_b, data_byte);
		count_n = base_count;
		quot_n = base_quot;
		rem_n = base_rem;
		esc_a_n = base_esc_a;
		esc_b_n = base_esc_b;
		if (store) begin
			count_n = base_count + 1'b1;
			if (base_rem == snf_pkg::REM_WRAP) begin
				rem_n = 8'd0;
				quot_n = base_quot + 1'b1;
			end else begin
				rem_n = base_rem + 8'd1;
			end
			esc_a_n = base_esc_a + snf_pkg::CNT_W'(step_a.inc);
			esc_b_n = base_esc_b + snf_pkg::CNT_W'(step_b.inc);
		end
		// Tracker b assumes a zero remainder byte just before the payload.
		esc_sel = (rem_n == 8'd0) ? esc_b_n : esc_a_n;
		nal_size_n = snf_pkg::NAL_W'(3) + snf_pkg::NAL_W'(quot_n) + snf_pkg::NAL_W'(count_n)
			+ snf_pkg::NAL_W'(esc_sel) + (codec_select ? snf_pkg::NAL_W'(2) : snf_pkg::NAL_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			quot_q <= '0;
			rem_q <= '0;
			zr_a_q <= 2'd0;
			zr_b_q <= 2'd1;
			esc_a_q <= '0;
			esc_b_q <= '0;
			ready_q <= 1'b0;
			ovf_q <= 1'b0;
			nal_size_q <= '0;
		end else if (done) begin
			count_q <= '0;
			quot_q <= '0;
			rem_q <= '0;
			zr_a_q <= 2'd0;
			zr_b_q <= 2'd1;
			esc_a_q <= '0;
			esc_b_q <= '0;
			ready_q <= 1'b0;
			ovf_q <= 1'b0;
			nal_size_q <= '0;
		end else if (load_en) begin
			count_q <= count_n;
			quot_q <= quot_n;
			rem_q <= rem_n;
			esc_a_q <= esc_a_n;
			esc_b_q <= esc_b_n;
			if (store) begin
				zr_a_q <= step_a.zr;
				zr_b_q <= step_b.zr;
			end else begin
				zr_a_q <= base_zr_a;
				zr_b_q <= base_zr_b;
			end
			ovf_q <= base_ovf | !store;
			ready_q <= last_byte;
			nal_size_q <= last_byte ? nal_size_n : '0;
		end
	end

	assign wr_en = load_en && store;
	assign wr_addr = base_count[snf_pkg::ADDR_W-1:0];

	assign msg.ready = ready_q;
	assign msg.overflow = ovf_q;
	assign msg.count = count_q;
	assign msg.quot = quot_q;
	assign msg.rem = rem_q;
	assign msg.nal_size = nal_size_q;

	a_ready_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (count_q != '0))
		else $error("Message marked ready with no payload bytes.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= snf_pkg::CNT_W'(snf_pkg::PAYLOAD_DEPTH))
		else $error("Payload count exceeds buffer depth.");

endmodule

// ----- hdl/snf_emitter.sv -----
// Output sequencer of the framer: prefix, NAL header and escaped RBSP, one byte per fetch.
// Depends on snf_pkg; reads payload bytes from the registered RAM read port, in the cycle after the address.
module snf_emitter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	input  logic                       active,
	input  snf_pkg::snf_msg_t          msg,
	input  logic                       codec_select,
	input  logic                       framing_mode,
	input  logic [7:0]                 rd_data,
	output logic [snf_pkg::ADDR_W-1:0] rd_addr,
	output snf_pkg::snf_emit_t         res
);

	snf_pkg::snf_phase_t        phase_q, phase_d;
	logic [1:0]                 pos_q, pos_d;
	logic [snf_pkg::QUOT_W-1:0] len_q, len_d;
	logic [snf_pkg::CNT_W-1:0]  rd_ptr_q, rd_ptr_d;
	logic [1:0]                 zr_q, zr_d;
	logic [7:0]                 v;
	logic [7:0]                 prefix_byte;
	logic [31:0]                size32;
	logic                       is_rbsp;
	logic                       esc_hit;
	snf_pkg::snf_esc_t          step;

	always_comb begin
		size32 = 32'(msg.nal_size);
		unique case (pos_q)
			2'd0: prefix_byte = framing_mode ? size32[31:24] : 8'd0;
			2'd1: prefix_byte = framing_mode ? size32[23:16] : 8'd0;
			2'd2: prefix_byte = framing_mode ? size32[15:8] : 8'd0;
			default: prefix_byte = framing_mode ? size32[7:0] : 8'd1;
		endcase
		is_rbsp = 1'b1;
		unique case (phase_q) inside
			snf_pkg::PH_PREFIX, snf_pkg::PH_HEADER: begin
				v = 8'd0;
				is_rbsp = 1'b0;
			end
			snf_pkg::PH_TYPE: v = snf_pkg::SEI_TYPE;
			snf_pkg::PH_LEN: v = snf_pkg::LEN_RUN;
			snf_pkg::PH_REM: v = msg.rem;
			snf_pkg::PH_PAY: v = rd_data;
			default: v = snf_pkg::TRAIL_BYTE;
		endcase
		step = snf_pkg::esc_step(zr_q, v);
		esc_hit = is_rbsp && step.inc;
	end

	always_comb begin
		res.last_out = 1'b0;
		res.done = 1'b0;
		unique case (phase_q)
			snf_pkg::PH_PREFIX: res.out_byte = prefix_byte;
			snf_pkg::PH_HEADER: begin
				if (!codec_select) begin
					res.out_byte = snf_pkg::H264_HDR;
				end else if (pos_q == 2'd0) begin
					res.out_byte = snf_pkg::H265_HDR0;
				end else begin
					res.out_byte = snf_pkg::H265_HDR1;
				end
			end
			default: begin
				res.out_byte = esc_hit ? snf_pkg::EPB : v;
				res.last_out = active && !esc_hit && (phase_q == snf_pkg::PH_TRAIL);
				res.done = res.last_out;
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		len_d = len_q;
		rd_ptr_d = rd_ptr_q;
		zr_d = zr_q;
		if (restart) begin
			phase_d = snf_pkg::PH_PREFIX;
			pos_d = 2'd0;
			len_d = '0;
			rd_ptr_d = '0;
			zr_d = 2'd0;
		end else if (active) begin
			if (esc_hit) begin
				zr_d = 2'd0;
			end else begin
				if (is_rbsp) begin
					zr_d = step.zr;
				end
				unique case (phase_q)
					snf_pkg::PH_PREFIX: begin
						pos_d = pos_q + 2'd1;
						if (pos_q == 2'd3) begin
							phase_d = snf_pkg::PH_HEADER;
						end
					end
					snf_pkg::PH_HEADER: begin
						if (!codec_select || pos_q != 2'd0) begin
							phase_d = snf_pkg::PH_TYPE;
							pos_d = 2'd0;
							zr_d = 2'd0;
						end else begin
							pos_d = 2'd1;
						end
					end
					snf_pkg::PH_TYPE: begin
						len_d = '0;
						phase_d = (msg.quot == '0) ? snf_pkg::PH_REM : snf_pkg::PH_LEN;
					end
					snf_pkg::PH_LEN: begin
						len_d = len_q + 1'b1;
						if (len_q == msg.quot - 1'b1) begin
							phase_d = snf_pkg::PH_REM;
						end
					end
					snf_pkg::PH_REM: begin
						rd_ptr_d = '0;
						phase_d = snf_pkg::PH_PAY;
					end
					snf_pkg::PH_PAY: begin
						rd_ptr_d = rd_ptr_q + 1'b1;
						if (rd_ptr_q + 1'b1 == msg.count) begin
							phase_d = snf_pkg::PH_TRAIL;
						end
					end
					default: begin
						phase_d = snf_pkg::PH_PREFIX;
						pos_d = 2'd0;
						len_d = '0;
						rd_ptr_d = '0;
						zr_d = 2'd0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= snf_pkg::PH_PREFIX;
			pos_q <= 2'd0;
			len_q <= '0;
			rd_ptr_q <= '0;
			zr_q <= 2'd0;
		end else begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			len_q <= len_d;
			rd_ptr_q <= rd_ptr_d;
			zr_q <= zr_d;
		end
	end

	assign rd_addr = rd_ptr_q[snf_pkg::ADDR_W-1:0];

	a_escape_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(active && esc_hit) |-> (phase_q == snf_pkg::PH_PAY))
		else $error("Emulation prevention byte outside the payload section.");

endmodule

// ----- hdl/sei_nal_framer_with_escaping_top.sv -----
// Top level of the SEI NAL framer with emulation prevention.
// Depends on snf_pkg, snf_if, snf_ram, snf_loader and snf_emitter.
//
// A load transaction writes one payload byte into the payload RAM while there is room; the
// byte count, the 255-run split of the size and the count of inserted emulation bytes are
// updated as each byte arrives, so the NAL size is known at the edge that takes the last
// byte and a fetch may follow at once. In a fetch transaction the payload RAM is read in the
// cycle of acceptance and the byte is formed from its registered read data in the next, and
// no new request is taken until that byte is formed. Loads run at one byte per cycle while
// the output register is free or being taken. A finished byte waits in an output register,
// and no transaction is taken while it waits unaccepted. No clearing pass is needed after reset.
module sei_nal_framer_with_escaping_top (
	input  logic                          clk,
	input  logic                          arst_n,
	snf_in_if.sink                        req,
	snf_out_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [snf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [snf_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                       codec_q, framing_q;
	logic                       valid_s1, err_s1;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       last_out_q, error_q;
	logic                       accept, load_en, fetch_en, restart, active;
	logic                       wr_en;
	logic [snf_pkg::ADDR_W-1:0] wr_addr, rd_addr;
	logic [7:0]                 rd_data;
	snf_pkg::snf_msg_t          msg;
	snf_pkg::snf_emit_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= 1'b0;
			framing_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				snf_pkg::CFG_CODEC_SELECT: codec_q <= cfg_data[0];
				snf_pkg::CFG_FRAMING_MODE: framing_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign req.ready = !valid_s1 && (!out_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;
	assign load_en = accept && (req.operation == snf_pkg::OP_LOAD);
	assign fetch_en = accept && (req.operation == snf_pkg::OP_FETCH);
	assign restart = load_en && req.last_byte;
	assign active = valid_s1 && !err_s1;

	snf_ram #(
		.WIDTH(8),
		.DEPTH(snf_pkg::PAYLOAD_DEPTH)
	) u_payload_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(req.data_byte),
		.re(fetch_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	snf_loader u_loader (
		.clk(clk),
		.arst_n(arst_n),
		.load_en(load_en),
		.data_byte(req.data_byte),
		.last_byte(req.last_byte),
		.codec_select(codec_q),
		.done(res.done),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.msg(msg)
	);

	snf_emitter u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.restart(restart),
		.active(active),
		.msg(msg),
		.codec_select(codec_q),
		.framing_mode(framing_q),
		.rd_data(rd_data),
		.rd_addr(rd_addr),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			err_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= fetch_en;
			err_s1 <= fetch_en && !msg.ready;
			if (valid_s1) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_byte_q <= err_s1 ? 8'd0 : res.out_byte;
			last_out_q <= !err_s1 && res.last_out;
			error_q <= err_s1 || msg.overflow;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.last_out = last_out_q;
	assign rsp.error_flag = error_q;

	a_s1_output_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !out_valid_q)
		else $error("Fetch result formed while the output register is occupied.");

	a_fetch_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_en |=> ##1 out_valid_q)
		else $error("Accepted fetch did not produce a result transaction.");

endmodule

// ----- verif/snf_framer_checker.sv -----
// Scoreboard for the SEI NAL framer: watches the request, result and register-write ports.
// Keeps its own model of the payload store and emitter and checks each result transaction.
// Depends on snf_pkg and the channel interfaces in snf_if.
module snf_framer_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	snf_in_if                             req,
	snf_out_if                            rsp,
	input  logic                          cfg_we,
	input  logic [snf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [snf_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                            errors,
	output int                            outstanding,
	output int                            bytes_checked,
	output logic                          message_open
);

	typedef enum logic [1:0] {
		SEG_PREFIX,
		SEG_HEADER,
		SEG_BODY
	} nal_seg_t;

	typedef struct packed {
		logic [7:0] value;
		logic last;
		logic err;
	} nal_byte_t;

	logic [7:0] payload_mem [snf_pkg::PAYLOAD_DEPTH];
	int payload_len;
	logic ready_flag;
	logic overflow_flag;
	nal_seg_t seg;
	int seg_pos;
	int zeros_seen;
	logic [31:0] size_word;
	logic codec_h265;
	logic size_framing;
	nal_byte_t expected_bytes[$];
	int fail_count;
	int check_count;

	function automatic int run_bytes();
		return payload_len / 255 + 1;
	endfunction

	function automatic int body_len();
		return run_bytes() + payload_len + 2;
	endfunction

	function automatic logic [7:0] body_byte(input int r);
		int lc;
		lc = run_bytes();
		if (r == 0)
			return snf_pkg::SEI_TYPE;
		if (r < lc)
			return snf_pkg::LEN_RUN;
		if (r == lc)
			return 8'(payload_len % 255);
		if (r <= lc + payload_len)
			return payload_mem[r - 1 - lc];
		return snf_pkg::TRAIL_BYTE;
	endfunction

	function automatic int escaped_body_len();
		int total;
		int zr;
		logic [7:0] v;
		total = 0;
		zr = 0;
		for (int r = 0; r < body_len(); r++) begin
			v = body_byte(r);
			if (zr >= 2 && v <= snf_pkg::EPB) begin
				total++;
				zr = 0;
			end
			total++;
			zr = (v == 8'd0) ? ((zr < 2) ? zr + 1 : 2) : 0;
		end
		return total;
	endfunction

	function automatic void drop_message();
		payload_len = 0;
		ready_flag = 1'b0;
		overflow_flag = 1'b0;
		seg = SEG_PREFIX;
		seg_pos = 0;
		zeros_seen = 0;
		size_word = '0;
	endfunction

	function automatic void take_load(input logic [7:0] d, input logic fin);
		if (ready_flag)
			drop_message();
		if (payload_len < snf_pkg::PAYLOAD_DEPTH) begin
			payload_mem[payload_len] = d;
			payload_len++;
		end else begin
			overflow_flag = 1'b1;
		end
		if (fin) begin
			// The size is fixed here with the header length of the codec in force now.
			ready_flag = 1'b1;
			size_word = 32'((codec_h265 ? 2 : 1) + escaped_body_len());
			seg = SEG_PREFIX;
			seg_pos = 0;
			zeros_seen = 0;
		end
	endfunction

	function automatic nal_byte_t next_nal_byte();
		nal_byte_t nb;
		logic [7:0] v;
		nb = '0;
		if (!ready_flag) begin
			nb.err = 1'b1;
			return nb;
		end
		nb.err = overflow_flag;
		case (seg)
			SEG_PREFIX: begin
				if (size_framing)
					nb.value = size_word[8 * (3 - seg_pos) +: 8];
				else
					nb.value = (seg_pos == 3) ? 8'd1 : 8'd0;
				seg_pos++;
				if (seg_pos >= 4) begin
					seg = SEG_HEADER;
					seg_pos = 0;
				end
			end
			SEG_HEADER: begin
				if (codec_h265)
					nb.value = (seg_pos == 0) ? snf_pkg::H265_HDR0 : snf_pkg::H265_HDR1;
				else
					nb.value = snf_pkg::H264_HDR;
				seg_pos++;
				if (seg_pos >= (codec_h265 ? 2 : 1)) begin
					seg = SEG_BODY;
					seg_pos = 0;
					zeros_seen = 0;
				end
			end
			default: begin
				v = body_byte(seg_pos);
				if (zeros_seen >= 2 && v <= snf_pkg::EPB) begin
					nb.value = snf_pkg::EPB;
					zeros_seen = 0;
				end else begin
					nb.value = v;
					zeros_seen = (v == 8'd0) ? ((zeros_seen < 2) ? zeros_seen + 1 : 2) : 0;
					seg_pos++;
					if (seg_pos >= body_len()) begin
						nb.last = 1'b1;
						drop_message();
					end
				end
			end
		endcase
		return nb;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		nal_byte_t got;
		nal_byte_t want;
		if (!arst_n) begin
			drop_message();
			codec_h265 = 1'b0;
			size_framing = 1'b0;
			expected_bytes.delete();
			fail_count = 0;
			check_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == snf_pkg::CFG_CODEC_SELECT)
					codec_h265 = cfg_data[0];
				else if (cfg_index == snf_pkg::CFG_FRAMING_MODE)
					size_framing = cfg_data[0];
			end
			if (req.valid && req.ready) begin
				if (req.operation == snf_pkg::OP_LOAD)
					take_load(req.data_byte, req.last_byte);
				else
					expected_bytes.insert(expected_bytes.size(), next_nal_byte());
			end
			if (rsp.valid && rsp.ready) begin
				got.value = rsp.out_byte;
				got.last = rsp.last_out;
				got.err = rsp.error_flag;
				check_count++;
				if (expected_bytes.size() == 0) begin
					fail_count++;
					$display("%0t: result transaction with nothing expected: byte %h last %b error %b",
						$time, got.value, got.last, got.err);
				end else begin
					want = expected_bytes.pop_front();
					if (got.value !== want.value || got.last !== want.last
							|| got.err !== want.err) begin
						fail_count++;
						$display("%0t: expected byte %h last %b error %b, got byte %h last %b error %b",
							$time, want.value, want.last, want.err, got.value, got.last, got.err);
					end
				end
			end
		end
		outstanding <= expected_bytes.size();
		message_open <= ready_flag;
		errors <= fail_count;
		bytes_checked <= check_count;
	end

endmodule

// ----- verif/tb_sei_nal_framer_with_escaping_top.sv -----
// Testbench top for the SEI NAL framer: clock, reset, stimulus, receiver stalls and verdict.
// Results are checked by snf_framer_checker; depends on snf_pkg, snf_if and the framer RTL.
module tb_sei_nal_framer_with_escaping_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_FETCHES = 16;
	localparam int RANDOM_ITEMS = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [snf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [snf_pkg::CFG_DATA_W-1:0] cfg_data;

	snf_in_if req ();
	snf_out_if rsp ();

	int errors;
	int outstanding;
	int bytes_checked;
	logic message_open;

	bit tx_idle_en;
	bit rx_idle_en;
	bit hold_request;
	int items_sent;
	int messages_sent;
	int abandoned;
	int config_writes;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	sei_nal_framer_with_escaping_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	snf_framer_checker u_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.outstanding(outstanding),
		.bytes_checked(bytes_checked),
		.message_open(message_open)
	);

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles.", quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result receiver: short random stalls, plus one long hold-off on request.
	initial begin
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp.ready <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 8'h00;
		if (r < 6)
			return 8'($urandom_range(1, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_item(input logic op, input logic [7:0] data, input logic fin);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.data_byte <= data;
		req.last_byte <= fin;
		do
			@(posedge clk);
		while (!req.ready);
		items_sent++;
		if (op == snf_pkg::OP_LOAD && fin)
			messages_sent++;
	endtask

	task automatic send_fetch();
		send_item(snf_pkg::OP_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Fetches until the scoreboard sees the message closed; the last fetch finds nothing ready.
	task automatic fetch_message();
		do
			send_fetch();
		while (message_open);
	endtask

	task automatic load_message(input int n, input bit lead_zeros);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = (lead_zeros && i < 2) ? 8'h00 : pick_byte();
			send_item(snf_pkg::OP_LOAD, b, i == n - 1);
		end
	endtask

	task automatic wait_for_results();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic codec, input logic framing);
		cfg_we <= 1'b1;
		cfg_index <= snf_pkg::CFG_CODEC_SELECT;
		cfg_data <= codec;
		@(posedge clk);
		cfg_index <= snf_pkg::CFG_FRAMING_MODE;
		cfg_data <= framing;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		config_writes += 2;
	endtask

	initial begin
		int random_start;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= snf_pkg::CFG_CODEC_SELECT;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.operation <= snf_pkg::OP_LOAD;
		req.data_byte <= 8'h00;
		req.last_byte <= 1'b0;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_request = 1'b0;
		items_sent = 0;
		messages_sent = 0;
		abandoned = 0;
		config_writes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(1'b0, 1'b0);
		send_item(snf_pkg::OP_FETCH, 8'hFF, 1'b1);
		send_item(snf_pkg::OP_LOAD, 8'h00, 1'b0);
		send_item(snf_pkg::OP_LOAD, 8'h00, 1'b0);
		send_item(snf_pkg::OP_LOAD, 8'h00, 1'b0);
		send_item(snf_pkg::OP_LOAD, 8'h00, 1'b0);
		send_item(snf_pkg::OP_LOAD, 8'h03, 1'b0);
		send_item(snf_pkg::OP_LOAD, 8'hFF, 1'b1);
		fetch_message();

		// The size is counted for H.265 but the message goes out with the H.264 header.
		wait_for_results();
		set_config(1'b1, 1'b1);
		send_item(snf_pkg::OP_LOAD, 8'hFF, 1'b0);
		send_item(snf_pkg::OP_LOAD, 8'h00, 1'b1);
		wait_for_results();
		set_config(1'b0, 1'b1);
		fetch_message();

		send_item(snf_pkg::OP_LOAD, 8'h00, 1'b1);
		send_fetch();
		send_fetch();
		abandoned++;
		send_item(snf_pkg::OP_LOAD, 8'h01, 1'b1);
		fetch_message();

		// Long hold-off on the result side while fetches keep coming.
		wait_for_results();
		set_config(1'b1, 1'b1);
		load_message(255, 1'b1);
		hold_request = 1'b1;
		repeat (HOLD_FETCHES) send_fetch();
		abandoned++;
		wait_for_results();

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		set_config(1'b0, 1'b1);

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (items_sent - random_start >= RANDOM_ITEMS * 4 / 5) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				tx_idle_en = 1'($urandom_range(0, 1));
				rx_idle_en = 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 3)) send_fetch();
			if ($urandom_range(0, 5) == 0) begin
				wait_for_results();
				set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 19) == 0)
				load_message($urandom_range(26, 60), 1'($urandom_range(0, 1)));
			else
				load_message($urandom_range(1, 24), $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0) begin
				wait_for_results();
				set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 6)) send_fetch();
				abandoned++;
			end else begin
				fetch_message();
			end
		end

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		wait_for_results();
		repeat (8) @(posedge clk);
		$display("Run covered %0d transactions in %0d messages, %0d of them cut short.",
			items_sent, messages_sent, abandoned);
		$display("%0d register writes, %0d result bytes compared.", config_writes, bytes_checked);
		if (errors == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/snf_pkg.sv
hdl/snf_if.sv
hdl/snf_ram.sv
hdl/snf_loader.sv
hdl/snf_emitter.sv
hdl/sei_nal_framer_with_escaping_top.sv
verif/snf_framer_checker.sv
verif/tb_sei_nal_framer_with_escaping_top.sv
